// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ATD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ATD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hdl/atan_deg_pkg.sv -----
// ----------------------------------------------------------------------------
// atan_deg_pkg
// Types, constants and helpers shared by the integer-degree arctangent blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atan_deg_pkg;

	localparam int COORD_W       = 16;
	localparam int MAG_W         = COORD_W + 1;
	localparam int ANGLE_W       = 9;
	localparam int TABLE_ENTRIES = 32;
	localparam int QUO_BITS      = $clog2(TABLE_ENTRIES);
	localparam int BASE_W        = 6;
	localparam int FIFO_DEPTH    = 2;

	localparam logic signed [ANGLE_W-1:0] ANGLE_0   = 9'sd0;
	localparam logic signed [ANGLE_W-1:0] ANGLE_90  = 9'sd90;
	localparam logic signed [ANGLE_W-1:0] ANGLE_180 = 9'sd180;
	localparam logic [BASE_W-1:0]         BASE_45   = 6'd45;

	localparam logic [BASE_W-1:0] DEG_TABLE [TABLE_ENTRIES] = '{
		6'd0,  6'd2,  6'd4,  6'd5,  6'd7,  6'd9,  6'd11, 6'd12,
		6'd14, 6'd16, 6'd17, 6'd19, 6'd21, 6'd22, 6'd24, 6'd25,
		6'd27, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33, 6'd35, 6'd36,
		6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44
	};

	// classified request handed from front to back
	typedef struct packed {
		logic                        special;     // axis or origin, angle is final
		logic signed [ANGLE_W-1:0]   fixed_angle;
		logic                        equal;       // |x| == |y|
		logic                        y_major;     // |x| < |y|
		logic                        x_pos;
		logic                        y_neg;
		logic [MAG_W-1:0]            num;         // smaller magnitude
		logic [MAG_W-1:0]            den;         // larger magnitude
	} item_t;

	typedef struct packed {
		logic             qbit;
		logic [MAG_W-1:0] rem;
	} div_step_t;

	// one restoring-division step; rem < den on entry and on exit
	function automatic div_step_t div_step(input logic [MAG_W-1:0] rem,
	                                      input logic [MAG_W-1:0] den);
		logic [MAG_W:0] shifted;
		div_step_t      r;
		shifted = {rem, 1'b0};
		if (shifted >= {1'b0, den}) begin
			r.qbit = 1'b1;
			r.rem  = MAG_W'(shifted - {1'b0, den});
		end else begin
			r.qbit = 1'b0;
			r.rem  = shifted[MAG_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/atan_deg_in_if.sv -----
// ----------------------------------------------------------------------------
// atan_deg_in_if
// Coordinate request channel: valid/ready handshake with y and x payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atan_deg_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [atan_deg_pkg::COORD_W-1:0] y_value;
	logic signed [atan_deg_pkg::COORD_W-1:0] x_value;

	modport source (output valid, output y_value, output x_value, input ready);
	modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

// ----- hdl/atan_deg_out_if.sv -----
// ----------------------------------------------------------------------------
// atan_deg_out_if
// Angle result channel: valid/ready handshake with the angle payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atan_deg_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [atan_deg_pkg::ANGLE_W-1:0] angle_degrees;

	modport source (output valid, output angle_degrees, input ready);
	modport sink   (input valid, input angle_degrees, output ready);
endinterface

// ----- hdl/atan_deg_front.sv -----
// ----------------------------------------------------------------------------
// atan_deg_front
// Takes coordinate requests, forms magnitudes and sorts out the special cases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atan_deg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	atan_deg_in_if.sink           coord,
	output logic                  push_valid,
	output atan_deg_pkg::item_t   push_item,
	input  logic                  push_ready
);

	logic signed [atan_deg_pkg::MAG_W-1:0] xs, ys;
	logic [atan_deg_pkg::MAG_W-1:0]        ax, ay;
	atan_deg_pkg::item_t                   item_c;
	atan_deg_pkg::item_t                   item_s1;
	logic                                  valid_s1;

	assign xs = {coord.x_value[atan_deg_pkg::COORD_W-1], coord.x_value};
	assign ys = {coord.y_value[atan_deg_pkg::COORD_W-1], coord.y_value};
	assign ax = coord.x_value[atan_deg_pkg::COORD_W-1] ? atan_deg_pkg::MAG_W'(-xs)
	                                                   : atan_deg_pkg::MAG_W'(xs);
	assign ay = coord.y_value[atan_deg_pkg::COORD_W-1] ? atan_deg_pkg::MAG_W'(-ys)
	                                                   : atan_deg_pkg::MAG_W'(ys);

	always_comb begin
		item_c             = '0;
		item_c.y_major     = ax < ay;
		item_c.equal       = ax == ay;
		item_c.x_pos       = !coord.x_value[atan_deg_pkg::COORD_W-1];
		item_c.y_neg       = coord.y_value[atan_deg_pkg::COORD_W-1];
		item_c.num         = (ax < ay) ? ax : ay;
		item_c.den         = (ax < ay) ? ay : ax;
		item_c.fixed_angle = atan_deg_pkg::ANGLE_0;
		if (ax == '0 && ay == '0) begin
			item_c.special = 1'b1;
		end else if (ax == '0) begin
			item_c.special     = 1'b1;
			item_c.fixed_angle = item_c.y_neg ? -atan_deg_pkg::ANGLE_90
			                                  : atan_deg_pkg::ANGLE_90;
		end else if (ay == '0) begin
			item_c.special     = 1'b1;
			item_c.fixed_angle = item_c.x_pos ? atan_deg_pkg::ANGLE_0
			                                  : atan_deg_pkg::ANGLE_180;
		end
	end

	assign coord.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coord.ready) begin
			valid_s1 <= coord.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coord.ready && coord.valid) begin
			item_s1 <= item_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	`ATD_ASSERT(a_front_order,
		(valid_s1 && !item_s1.special) |-> (item_s1.num <= item_s1.den &&
		((item_s1.num == item_s1.den) == item_s1.equal)),
		"front: magnitudes not sorted")

endmodule

// ----- hdl/atan_deg_fifo.sv -----
// ----------------------------------------------------------------------------
// atan_deg_fifo
// Small show-ahead queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atan_deg_fifo #(
	parameter int DEPTH = atan_deg_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  atan_deg_pkg::item_t   push_item,
	output logic                  push_ready,
	output logic                  pop_valid,
	output atan_deg_pkg::item_t   pop_item,
	input  logic                  pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	atan_deg_pkg::item_t entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`ATD_ASSERT(a_fifo_bound, count_q <= CNT_W'(DEPTH), "fifo: count beyond depth")
	`ATD_ASSERT_NEVER(a_fifo_overrun, push_valid && !push_ready && $past(push_ready) &&
		$past(count_q) == '0, "fifo: filled from empty in one cycle")

endmodule

// ----- hdl/atan_deg_back.sv -----
// ----------------------------------------------------------------------------
// atan_deg_back
// Five-stage quotient pipeline, table lookup and quadrant fold to the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atan_deg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  atan_deg_pkg::item_t   pop_item,
	output logic                  pop_ready,
	atan_deg_out_if.source        angle
);

	localparam int NS = atan_deg_pkg::QUO_BITS;

	atan_deg_pkg::item_t                    item_s  [NS];
	logic [atan_deg_pkg::MAG_W-1:0]         rem_s   [NS];
	logic [NS-1:0]                          quo_s   [NS];
	logic [NS-1:0]                          valid_s;
	atan_deg_pkg::div_step_t                step_c  [NS];
	logic                                   out_valid_q;
	logic signed [atan_deg_pkg::ANGLE_W-1:0] angle_q;
	logic signed [atan_deg_pkg::ANGLE_W-1:0] angle_c;
	logic                                   adv;

	function automatic logic signed [atan_deg_pkg::ANGLE_W-1:0] fold(
		input atan_deg_pkg::item_t it, input logic [atan_deg_pkg::BASE_W-1:0] base);
		logic signed [atan_deg_pkg::ANGLE_W-1:0] b;
		logic signed [atan_deg_pkg::ANGLE_W-1:0] r;
		b = $signed({{(atan_deg_pkg::ANGLE_W - atan_deg_pkg::BASE_W){1'b0}}, base});
		if (it.x_pos && !it.y_neg) begin
			r = it.y_major ? atan_deg_pkg::ANGLE_90 - b : b;
		end else if (it.x_pos) begin
			r = it.y_major ? b - atan_deg_pkg::ANGLE_90 : -b;
		end else if (it.y_neg) begin
			r = it.y_major ? -atan_deg_pkg::ANGLE_90 - b : b - atan_deg_pkg::ANGLE_180;
		end else begin
			r = it.y_major ? atan_deg_pkg::ANGLE_90 + b : atan_deg_pkg::ANGLE_180 - b;
		end
		return r;
	endfunction

	// whole pipeline moves together; it holds only when the result is not taken
	assign adv       = !out_valid_q || angle.ready;
	assign pop_ready = adv;

	always_comb begin
		step_c[0] = atan_deg_pkg::div_step(pop_item.num, pop_item.den);
		for (int i = 1; i < NS; i++) begin
			step_c[i] = atan_deg_pkg::div_step(rem_s[i-1], item_s[i-1].den);
		end
	end

	always_comb begin
		logic [atan_deg_pkg::BASE_W-1:0] base;
		base = item_s[NS-1].equal ? atan_deg_pkg::BASE_45
		                          : atan_deg_pkg::DEG_TABLE[quo_s[NS-1]];
		angle_c = item_s[NS-1].special ? item_s[NS-1].fixed_angle
		                               : fold(item_s[NS-1], base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s     <= {valid_s[NS-2:0], pop_valid};
			out_valid_q <= valid_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s[0] <= pop_item;
			rem_s[0]  <= step_c[0].rem;
			quo_s[0]  <= NS'(step_c[0].qbit);
			for (int i = 1; i < NS; i++) begin
				item_s[i] <= item_s[i-1];
				rem_s[i]  <= step_c[i].rem;
				quo_s[i]  <= {quo_s[i-1][NS-2:0], step_c[i].qbit};
			end
			angle_q <= angle_c;
		end
	end

	assign angle.valid         = out_valid_q;
	assign angle.angle_degrees = angle_q;

	`ATD_ASSERT(a_back_rem,
		(valid_s[NS-1] && !item_s[NS-1].special && !item_s[NS-1].equal) |->
		(rem_s[NS-1] < item_s[NS-1].den), "back: remainder not below divisor")
	`ATD_ASSERT(a_back_range,
		out_valid_q |-> (angle_q >= -atan_deg_pkg::ANGLE_180 &&
		angle_q <= atan_deg_pkg::ANGLE_180), "back: angle out of range")

endmodule

// ----- hdl/table_arctan2_degrees.sv -----
// One (y, x) request is taken per clock while the front is not stalled, and each
// gives one angle in whole degrees, -180 to +180, with origin and axis points
// handled exactly (origin gives 0, the negative x axis gives +180). Throughput
// is one request per cycle while no stall holds the flow. A request passes
// through the front register, one pass through the decoupling queue, five
// divider stages that each produce one bit of the 5-bit quotient min*32/max,
// and the table lookup and quadrant fold into the output register. The front
// and back stall independently; the queue absorbs up to FIFO_DEPTH requests
// while the result side is held.
// ----------------------------------------------------------------------------
// table_arctan2_degrees
// Four-quadrant arctangent in integer degrees from a 32-entry angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_arctan2_degrees #(
	parameter int FIFO_DEPTH = atan_deg_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	atan_deg_in_if.sink      coord,
	atan_deg_out_if.source   angle
);

	atan_deg_pkg::item_t push_item, pop_item;
	logic                push_valid, push_ready;
	logic                pop_valid, pop_ready;

	atan_deg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord      (coord),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	atan_deg_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	atan_deg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.angle     (angle)
	);

endmodule
